### rtl/core/pdcc_pkg.sv
// ----------------------------------------------------------------------------
// pdcc_pkg
// Shared types and constants for the pixel decay-chain correlator.
// ----------------------------------------------------------------------------
package pdcc_pkg;

	localparam int unsigned DefXStrips   = 40;
	localparam int unsigned DefYStrips   = 40;
	localparam int unsigned DefChainDepth = 16;

	localparam int unsigned PixW   = 12;
	localparam int unsigned InfoW  = 31;
	localparam int unsigned TimeW  = 48;
	localparam int unsigned InDataW  = 88;
	localparam int unsigned OutDataW = 104;

	localparam logic [2:0] KIND_ALPHA   = 3'd1;
	localparam logic [2:0] KIND_HEAVY   = 3'd2;
	localparam logic [2:0] KIND_FISSION = 3'd3;

	localparam logic STATUS_RECORD = 1'b0;
	localparam logic STATUS_ERROR  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_META,
		ST_DECIDE,
		ST_APPEND,
		ST_CLOSE,
		ST_HEAD,
		ST_RD,
		ST_LOAD,
		ST_OUT,
		ST_EWAIT,
		ST_WB
	} state_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic meta_cap;
		logic append;
		logic close;
		logic head_cap;
		logic out_load;
		logic idx_inc;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic range_bad;
		logic kind_heavy;
		logic kind_fission;
		logic flush_ok;
		logic head_ok;
		logic idx_last;
		logic out_fire;
	} sts_t;

endpackage

### rtl/core/pdcc_ctrl.sv
// ----------------------------------------------------------------------------
// pdcc_ctrl
// Sequencer: clearing pass, append/close ordering and chain replay.
// ----------------------------------------------------------------------------
module pdcc_ctrl import pdcc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_fire,
	input  sts_t   sts,
	output logic   in_ready,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.take = 1'b1;
					state_d  = sts.range_bad ? ST_EWAIT : ST_META;
				end
			end
			ST_META: begin
				cmd.meta_cap = 1'b1;
				state_d      = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = sts.kind_heavy ? ST_CLOSE : ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = sts.kind_fission ? ST_CLOSE : ST_WB;
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				if (sts.flush_ok) state_d = ST_HEAD;
				else state_d = sts.kind_heavy ? ST_APPEND : ST_WB;
			end
			ST_HEAD: begin
				cmd.head_cap = 1'b1;
				if (sts.head_ok) state_d = ST_RD;
				else state_d = sts.kind_heavy ? ST_APPEND : ST_WB;
			end
			ST_RD: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_fire) begin
					if (sts.idx_last) begin
						state_d = sts.kind_heavy ? ST_APPEND : ST_WB;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_RD;
					end
				end
			end
			ST_EWAIT: begin
				if (sts.out_fire) state_d = ST_IDLE;
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/pdcc_dp.sv
// ----------------------------------------------------------------------------
// pdcc_dp
// Datapath: per-pixel counters, event store, output record register.
// ----------------------------------------------------------------------------
module pdcc_dp import pdcc_pkg::*; #(
	parameter int unsigned X_STRIPS    = DefXStrips,
	parameter int unsigned Y_STRIPS    = DefYStrips,
	parameter int unsigned CHAIN_DEPTH = DefChainDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,
	output logic [3:0]          m_tuser,
	output logic                m_tlast
);

	localparam int unsigned SlotW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int unsigned EvW   = TimeW + InfoW;
	localparam logic [7:0] Depth8 = 8'(CHAIN_DEPTH);
	localparam logic [5:0] XMax   = 6'(X_STRIPS);
	localparam logic [5:0] YMax   = 6'(Y_STRIPS);

	// memories
	logic [15:0]    meta_mem [2**PixW];
	logic [EvW-1:0] ev_mem   [2**(PixW+SlotW)];
	logic [15:0]    meta_rd_q;
	logic [EvW-1:0] ev_rd_q;

	logic [PixW-1:0]  clr_cnt_q;
	logic [5:0]       x_q, y_q;
	logic [2:0]       kind_q;
	logic [InfoW-1:0] info_q;
	logic [TimeW-1:0] time_q;
	logic [7:0]       len_q, alpha_q, cl_len_q, cl_alpha_q;
	logic [TimeW-1:0] t0_q;
	logic [SlotW-1:0] idx_q;
	logic             out_valid_q, out_status_q, out_last_q, out_trunc_q;
	logic [5:0]       out_x_q, out_y_q;
	logic [2:0]       out_kind_q, out_flags_q;
	logic [15:0]      out_energy_q;
	logic [TimeW-1:0] out_time_q;
	logic [8:0]       out_chamber_q;
	logic [7:0]       out_alpha_q;

	logic [5:0]       in_x, in_y;
	logic [PixW-1:0]  in_pix;
	logic [7:0]       stored;
	logic [SlotW-1:0] rd_slot;
	logic [InfoW-1:0] rd_info;
	logic             out_fire;

	assign in_x     = s_tdata[5:0];
	assign in_y     = s_tdata[11:6];
	assign in_pix   = {in_x, in_y};
	assign stored   = (cl_len_q > Depth8) ? Depth8 : cl_len_q;
	assign rd_slot  = cmd.close ? '0 : idx_q;
	assign rd_info  = ev_rd_q[InfoW-1:0];
	assign out_fire = out_valid_q && m_tready;

	// status back to the sequencer
	always_comb begin
		sts              = '0;
		sts.clr_last     = &clr_cnt_q;
		sts.range_bad    = (in_x > XMax) || (in_y > YMax);
		sts.kind_heavy   = (kind_q == KIND_HEAVY);
		sts.kind_fission = (kind_q == KIND_FISSION);
		sts.flush_ok     = (len_q != 8'd0) && (alpha_q >= 8'd2);
		sts.head_ok      = (rd_info[2:0] == KIND_HEAVY);
		sts.idx_last     = ({{(8-SlotW){1'b0}}, idx_q} + 8'd1) == stored;
		sts.out_fire     = out_fire;
	end

	// per-pixel counter memory
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			meta_mem[clr_cnt_q] <= '0;
		end else if (cmd.wb) begin
			meta_mem[{x_q, y_q}] <= {alpha_q, len_q};
		end
		meta_rd_q <= meta_mem[in_pix];
	end

	// event store
	always_ff @(posedge clk) begin
		if (cmd.append && (len_q < Depth8)) begin
			ev_mem[{x_q, y_q, len_q[SlotW-1:0]}] <= {time_q, info_q};
		end
		ev_rd_q <= ev_mem[{x_q, y_q, rd_slot}];
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// capture the item and work on the chain counters
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q    <= in_x;
			y_q    <= in_y;
			kind_q <= s_tuser;
			time_q <= s_tdata[75:28];
			info_q <= {s_tdata[87:85], s_tdata[84:76], s_tdata[27:12], s_tuser};
		end
		if (cmd.meta_cap) begin
			len_q   <= meta_rd_q[7:0];
			alpha_q <= meta_rd_q[15:8];
		end else if (cmd.append) begin
			if (len_q != 8'hFF) len_q <= len_q + 8'd1;
			if ((kind_q == KIND_ALPHA) && (alpha_q != 8'hFF)) alpha_q <= alpha_q + 8'd1;
		end else if (cmd.close) begin
			cl_len_q   <= len_q;
			cl_alpha_q <= alpha_q;
			len_q      <= '0;
			alpha_q    <= '0;
		end
		if (cmd.close) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.head_cap) begin
			t0_q <= ev_rd_q[EvW-1:InfoW];
		end
	end

	// output record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load || (cmd.take && sts.range_bad)) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && sts.range_bad) begin
			out_status_q  <= STATUS_ERROR;
			out_x_q       <= in_x;
			out_y_q       <= in_y;
			out_kind_q    <= '0;
			out_energy_q  <= '0;
			out_time_q    <= '0;
			out_chamber_q <= '0;
			out_flags_q   <= '0;
			out_alpha_q   <= '0;
			out_trunc_q   <= 1'b0;
			out_last_q    <= 1'b1;
		end else if (cmd.out_load) begin
			out_status_q  <= STATUS_RECORD;
			out_x_q       <= x_q;
			out_y_q       <= y_q;
			out_kind_q    <= rd_info[2:0];
			out_energy_q  <= rd_info[18:3];
			out_time_q    <= ev_rd_q[EvW-1:InfoW] - t0_q;
			out_chamber_q <= rd_info[27:19];
			out_flags_q   <= rd_info[30:28];
			out_alpha_q   <= cl_alpha_q;
			out_trunc_q   <= cl_len_q > Depth8;
			out_last_q    <= sts.idx_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_kind_q, out_status_q};
	assign m_tdata  = {7'd0, out_trunc_q, out_alpha_q, out_flags_q, out_chamber_q,
		out_time_q, out_energy_q, out_y_q, out_x_q};

	// never overwrite a record still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q) else $error("record overwritten");
	// no chain update while a record is pending
	a_append_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> !out_valid_q) else $error("append with record pending");
	// an error record is always a last record
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_ERROR) |-> out_last_q)
		else $error("error record without last");

endmodule

### rtl/core/pixel_decay_chain_correlator_core.sv
// ----------------------------------------------------------------------------
// pixel_decay_chain_correlator_core
// Keeps one bounded event chain per pixel and replays qualifying chains.
//
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tdata: detector event, tuser: event kind
// m_*      out  tvalid/tready    tdata: chain record, tuser: status+kind, tlast
//
// After reset a clearing pass zeroes the per-pixel counters; s_tready stays
// low meanwhile. A new item is taken only after the last one is done: a
// plain append passes META, DECIDE, APPEND and WB; an event that closes a
// chain adds CLOSE, plus the head check in HEAD if the chain qualifies; an
// out-of-range item waits in EWAIT until m_tready takes its error record.
// A heavy head replays each record in RD, LOAD and OUT; OUT waits on m_tready.
// ----------------------------------------------------------------------------
module pixel_decay_chain_correlator_core import pdcc_pkg::*; #(
	parameter int unsigned X_STRIPS    = DefXStrips,
	parameter int unsigned Y_STRIPS    = DefYStrips,
	parameter int unsigned CHAIN_DEPTH = DefChainDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// strip_x, strip_y, energy_value, timestamp, chamber_hits, beam_on,
	// veto_hit, escape_hit
	input  logic [InDataW-1:0]  s_tdata,
	// event_kind
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// pixel_x, pixel_y, record_energy, relative_time, record_chamber,
	// record_flags, alpha_total, truncated, zero pad
	output logic [OutDataW-1:0] m_tdata,
	// status, record_kind
	output logic [3:0]          m_tuser,
	output logic                m_tlast
);

	cmd_t cmd;
	sts_t sts;

	pdcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid && s_tready),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	pdcc_dp #(
		.X_STRIPS    (X_STRIPS),
		.Y_STRIPS    (Y_STRIPS),
		.CHAIN_DEPTH (CHAIN_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
